/* design/bc1_pkg.sv */
// Types, constants and helper functions for the BC1 block decoder.
// No dependencies; imported by bc1_block_decoder_core.
`default_nettype none

package bc1_pkg;

  // Number of rows and columns in one block
  localparam int unsigned BlkRows = 4;
  localparam int unsigned BlkCols = 4;

  // floor(x / 3) == (x * Recip3) >> Recip3Shift for every x up to 3 * 255
  localparam int unsigned Recip3      = 683;
  localparam int unsigned Recip3Shift = 11;

  localparam logic [7:0]  AlphaOpaque = 8'hFF;
  localparam logic [31:0] PixNearBlk  = 32'hFF01_0101;
  localparam logic [31:0] PixClear    = 32'h0000_0000;

  // Three 8-bit channels; index 0 is pixel byte 0
  typedef logic [2:0][7:0] ch3_t;
  // Three 10-bit interpolation sums
  typedef logic [2:0][9:0] sum3_t;
  // Palette of four 32-bit pixels
  typedef logic [3:0][31:0] pal_t;
  // Palette indices: one byte per row, 2 bits per column
  typedef logic [3:0][3:0][1:0] idx_t;

  function automatic ch3_t expand565(input logic [15:0] v);
    ch3_t c;
    c[0] = {v[4:0], v[4:2]};
    c[1] = {v[10:5], v[10:9]};
    c[2] = {v[15:11], v[15:13]};
    return c;
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = {10'd0, x} * 20'(Recip3);
    return p[Recip3Shift +: 8];
  endfunction

  // Opaque pixel; pure black is lifted to 1,1,1
  function automatic logic [31:0] pack_opaque(input ch3_t c);
    logic [31:0] p;
    if (c == '0) begin
      p = PixNearBlk;
    end else begin
      p = {AlphaOpaque, c};
    end
    return p;
  endfunction

endpackage

`default_nettype wire

/* design/bc1_block_decoder_core.sv */
// BC1 block decoder: five-stage pipeline from compressed block to pixel rows.
// Depends on bc1_pkg (types, 5:6:5 expansion, divide-by-three, pixel packing).
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o / block_i): one transaction is one
//    8-byte BC1 block, byte 0 in bits 7:0. Endpoint 0 is bytes 0..1, endpoint
//    1 is bytes 2..3, bytes 4..7 carry the 2-bit indices of rows 0..3.
//  - Output channel (out_valid_o / out_ready_i): four transactions per block,
//    rows 0..3 in order, each with four 32-bit pixels (bytes c0, g, c2, alpha)
//    and last_o set on row 3.
//  - Path: a block passes expand (loaded on the accepting edge), then sum,
//    divide, pack and the row register before row 0 is presented.
//  - Throughput: set by the single output channel, which delivers one row per
//    cycle while out_ready_i is high. Up to four more blocks sit in the
//    pipeline stages while the row register drains, so input is taken every
//    cycle until those stages fill.
//  - Stalls: each stage holds its contents when the stage after it is full
//    and not moving; nothing is dropped or repeated. in_ready_o drops only
//    when every stage holds a block.
//  - Reset (rst_ni low, asynchronous): all stage valid bits and the row
//    counter clear; the block is ready right after reset.
`default_nettype none

module bc1_block_decoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] block_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       row_o,
  output logic [31:0]      pix0_o,
  output logic [31:0]      pix1_o,
  output logic [31:0]      pix2_o,
  output logic [31:0]      pix3_o,
  output logic             last_o
);

  import bc1_pkg::*;

  localparam logic [1:0] RowLast = 2'(BlkRows - 1);

  // Stage enables: a stage loads when it is empty or its content moves on
  logic en1, en2, en3, en4, en_out;
  logic out_fire, row_done;

  // Stage 1: expanded endpoints and mode
  logic v1_q;
  ch3_t s1_c0_q, s1_c1_q;
  logic s1_three_q;
  idx_t s1_idx_q;

  // Stage 2: sums
  logic v2_q;
  ch3_t s2_c0_q, s2_c1_q, s2_mean_q, s2_mean_d;
  sum3_t s2_sa_q, s2_sb_q, s2_sa_d, s2_sb_d;
  logic s2_three_q;
  idx_t s2_idx_q;

  // Stage 3: interpolated colours
  logic v3_q;
  ch3_t s3_c0_q, s3_c1_q, s3_c2_q, s3_c3_q, s3_c2_d, s3_c3_d;
  logic s3_three_q;
  idx_t s3_idx_q;

  // Stage 4: packed palette
  logic v4_q;
  pal_t s4_pal_q, s4_pal_d;
  idx_t s4_idx_q;

  // Row register
  logic ov_q;
  pal_t pal_q;
  idx_t idx_q;
  logic [1:0] row_q, row_d;

  assign out_fire   = ov_q && out_ready_i;
  assign row_done   = out_fire && (row_q == RowLast);
  assign en_out     = !ov_q || row_done;
  assign en4        = !v4_q || en_out;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // ---------------------------------------------------------------- valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      ov_q  <= 1'b0;
      row_q <= '0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en_out) ov_q <= v4_q;
      row_q <= row_d;
    end
  end

  always_comb begin
    row_d = row_q;
    if (en_out && v4_q) begin
      row_d = '0;
    end else if (out_fire) begin
      row_d = row_q + 2'd1;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_c0_q    <= expand565(block_i[15:0]);
      s1_c1_q    <= expand565(block_i[31:16]);
      s1_three_q <= (block_i[15:0] <= block_i[31:16]);
      s1_idx_q   <= block_i[63:32];
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s2_sa_d[c]   = {1'b0, s1_c0_q[c], 1'b0} + {2'b00, s1_c1_q[c]};
      s2_sb_d[c]   = {2'b00, s1_c0_q[c]} + {1'b0, s1_c1_q[c], 1'b0};
      s2_mean_d[c] = 8'(({1'b0, s1_c0_q[c]} + {1'b0, s1_c1_q[c]}) >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      s2_c0_q    <= s1_c0_q;
      s2_c1_q    <= s1_c1_q;
      s2_mean_q  <= s2_mean_d;
      s2_sa_q    <= s2_sa_d;
      s2_sb_q    <= s2_sb_d;
      s2_three_q <= s1_three_q;
      s2_idx_q   <= s1_idx_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s3_c2_d[c] = s2_three_q ? s2_mean_q[c] : div3(s2_sa_q[c]);
      s3_c3_d[c] = s2_three_q ? 8'd0 : div3(s2_sb_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      s3_c0_q    <= s2_c0_q;
      s3_c1_q    <= s2_c1_q;
      s3_c2_q    <= s3_c2_d;
      s3_c3_q    <= s3_c3_d;
      s3_three_q <= s2_three_q;
      s3_idx_q   <= s2_idx_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  always_comb begin
    s4_pal_d[0] = pack_opaque(s3_c0_q);
    s4_pal_d[1] = pack_opaque(s3_c1_q);
    s4_pal_d[2] = pack_opaque(s3_c2_q);
    s4_pal_d[3] = s3_three_q ? PixClear : pack_opaque(s3_c3_q);
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      s4_pal_q <= s4_pal_d;
      s4_idx_q <= s3_idx_q;
    end
  end

  // ---------------------------------------------------------- row register
  always_ff @(posedge clk_i) begin
    if (en_out && v4_q) begin
      pal_q <= s4_pal_q;
      idx_q <= s4_idx_q;
    end
  end

  assign out_valid_o = ov_q;
  assign row_o       = row_q;
  assign last_o      = (row_q == RowLast);
  assign pix0_o      = pal_q[idx_q[row_q][0]];
  assign pix1_o      = pal_q[idx_q[row_q][1]];
  assign pix2_o      = pal_q[idx_q[row_q][2]];
  assign pix3_o      = pal_q[idx_q[row_q][3]];

  // ------------------------------------------------------------ assertions
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (row_q != RowLast) |=> ov_q && (row_q == $past(row_q) + 2'd1))
    else $error("row counter did not advance after a row transaction");

  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted block missing from stage 1");

  a_pal0_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (pal_q[0][31:24] == AlphaOpaque) && (pal_q[0][23:0] != 24'd0))
    else $error("endpoint 0 not opaque or left pure black");

  a_s4_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !en_out |=> v4_q && $stable(s4_pal_q))
    else $error("stage 4 lost its block during a stall");

  a_row0_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_out && v4_q |=> ov_q && (row_q == 2'd0))
    else $error("new block did not start at row 0");

endmodule

`default_nettype wire

/* tb/bc1_block_decoder_core_test.sv */
// Self-checking testbench for bc1_block_decoder_core: drives BC1 blocks, predicts
// the four pixel rows of each block and compares every row field by field.
// Depends only on the RTL (bc1_pkg and bc1_block_decoder_core).
`timescale 1ns / 1ps

module bc1_block_decoder_core_test;

  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 5;
  localparam int PipeLatency = 5;
  localparam int HoldCycles  = 60;
  localparam int MaxGap      = 6;
  localparam int PhaseItems  = 50;
  localparam int HoldAtItem  = 10;
  localparam int StallLimit  = 2000;

  localparam logic [31:0] OpaqueNearBlack = 32'hFF01_0101;
  localparam logic [31:0] ClearBlack      = 32'h0000_0000;
  localparam logic [7:0]  AlphaFull       = 8'hFF;

  // Single-channel endpoint masks: low channel, green, high channel
  localparam logic [15:0] MaskLo    = 16'h001F;
  localparam logic [15:0] MaskGreen = 16'h07E0;
  localparam logic [15:0] MaskHi    = 16'hF800;

  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic [1:0]       row;
    logic [3:0][31:0] pix;
    logic             last;
  } pixel_row_t;

  // Directed block; when known is set every pixel of the block equals pix
  typedef struct {
    logic [63:0] blk;
    bit          known;
    logic [31:0] pix;
  } block_stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] block_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  row_o;
  logic [31:0] pix0_o;
  logic [31:0] pix1_o;
  logic [31:0] pix2_o;
  logic [31:0] pix3_o;
  logic        last_o;

  pixel_row_t pending_rows[$];
  int         mismatch_count = 0;
  int         send_idle_pct  = 20;
  int         recv_idle_pct  = 61;
  bit         hold_rows      = 1'b0;
  int         stall_cycles   = 0;

  block_stim_t directed_tbl [16] = '{
    '{64'h0000_0000_0000_0000, 1'b1, OpaqueNearBlack}, // black endpoints, equal
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ClearBlack},      // all index 3, three-color
    '{64'h0000_0000_0000_FFFF, 1'b1, 32'hFFFF_FFFF},   // white endpoint 0
    '{64'h5555_5555_0000_FFFF, 1'b1, OpaqueNearBlack}, // black endpoint 1 lifted
    '{64'h0000_0000_0000_001F, 1'b1, 32'hFF00_00FF},   // low channel -> byte 0
    '{64'h0000_0000_0000_07E0, 1'b1, 32'hFF00_FF00},   // green -> byte 1
    '{64'h0000_0000_0000_F800, 1'b1, 32'hFFFF_0000},   // high channel -> byte 2
    '{64'hAAAA_AAAA_0000_FFFF, 1'b0, '0},              // first third
    '{64'hFFFF_FFFF_0000_FFFF, 1'b0, '0},              // second third
    '{64'hE4E4_E4E4_1234_1234, 1'b0, '0},              // equal endpoints
    '{64'h1B1B_1B1B_1234_1235, 1'b0, '0},              // e0 one above e1
    '{64'hE4E4_E4E4_1235_1234, 1'b0, '0},              // e0 one below e1
    '{64'h00FF_AA55_0000_0001, 1'b0, '0},              // thirds truncate
    '{64'hAAAA_AAAA_0001_0000, 1'b0, '0},              // three-color mean
    '{64'h3C96_E41B_8410_7BEF, 1'b0, '0},
    '{64'h6C39_C693_7BEF_8410, 1'b0, '0}
  };

  bc1_block_decoder_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .block_i     (block_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_o       (row_o),
    .pix0_o      (pix0_o),
    .pix1_o      (pix1_o),
    .pix2_o      (pix2_o),
    .pix3_o      (pix3_o),
    .last_o      (last_o)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // 5:6:5 endpoint to three 8-bit channels by bit replication
  function automatic rgb_t widen565(input logic [15:0] v);
    int   lo;
    int   g;
    int   hi;
    rgb_t ch;
    lo = int'(v & 16'h001F);
    g  = int'((v >> 5) & 16'h003F);
    hi = int'((v >> 11) & 16'h001F);
    ch[0] = 8'((lo << 3) | (lo >> 2));
    ch[1] = 8'((g << 2) | (g >> 4));
    ch[2] = 8'((hi << 3) | (hi >> 2));
    return ch;
  endfunction

  function automatic logic [31:0] opaque_pixel(input rgb_t ch);
    logic [31:0] p;
    if (ch == '0) begin
      p = OpaqueNearBlack;
    end else begin
      p = {AlphaFull, ch[2], ch[1], ch[0]};
    end
    return p;
  endfunction

  // Appends one expected row to the tail of the queue
  task automatic queue_row(input pixel_row_t r);
    pending_rows = {pending_rows, r};
  endtask

  // Builds the palette of one block and queues the four rows it decodes to
  task automatic decode_block_rows(input logic [63:0] blk);
    logic [15:0]      e0;
    logic [15:0]      e1;
    rgb_t             c0;
    rgb_t             c1;
    rgb_t             mid;
    rgb_t             far;
    logic [3:0][31:0] pal;
    bit               three;
    logic [7:0]       idx;
    pixel_row_t       r;
    e0    = blk[15:0];
    e1    = blk[31:16];
    three = (e0 <= e1);
    c0    = widen565(e0);
    c1    = widen565(e1);
    for (int k = 0; k < 3; k++) begin
      if (three) begin
        mid[k] = 8'((int'(c0[k]) + int'(c1[k])) / 2);
        far[k] = 8'd0;
      end else begin
        mid[k] = 8'((2 * int'(c0[k]) + int'(c1[k])) / 3);
        far[k] = 8'((int'(c0[k]) + 2 * int'(c1[k])) / 3);
      end
    end
    pal[0] = opaque_pixel(c0);
    pal[1] = opaque_pixel(c1);
    pal[2] = opaque_pixel(mid);
    pal[3] = three ? ClearBlack : opaque_pixel(far);
    for (int rr = 0; rr < 4; rr++) begin
      idx   = blk[32 + 8 * rr +: 8];
      r.row = 2'(rr);
      for (int c = 0; c < 4; c++) begin
        r.pix[c] = pal[idx[2 * c +: 2]];
      end
      r.last = (rr == 3);
      queue_row(r);
    end
  endtask

  // Random block biased toward mode boundaries, black and single channels
  function automatic logic [63:0] random_block();
    logic [31:0] idx;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] m;
    int          kind;
    idx  = $urandom;
    a    = 16'($urandom);
    b    = 16'($urandom);
    kind = $urandom_range(99);
    if (kind < 20) begin
      b = a;
    end else if (kind < 35) begin
      b = ($urandom_range(1) == 1) ? a + 16'd1 : a - 16'd1;
    end else if (kind < 45) begin
      if ($urandom_range(1) == 1) begin
        a = '0;
      end else begin
        b = '0;
      end
    end else if (kind < 60) begin
      case ($urandom_range(2))
        0: m = MaskLo;
        1: m = MaskGreen;
        default: m = MaskHi;
      endcase
      a &= m;
      b &= m;
    end
    return {idx, b, a};
  endfunction

  // Offers one block, waits for the transaction, then records what it must give
  task automatic send_block(input logic [63:0] blk, input bit known, input logic [31:0] pix);
    int         gaps;
    pixel_row_t r;
    gaps = 0;
    while (gaps < MaxGap && $urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid_i <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    block_i    <= blk;
    do @(posedge clk_i); while (!in_ready_o);
    if (known) begin
      for (int rr = 0; rr < 4; rr++) begin
        r.row  = 2'(rr);
        r.pix  = {4{pix}};
        r.last = (rr == 3);
        queue_row(r);
      end
    end else begin
      decode_block_rows(blk);
    end
  endtask

  task automatic wait_rows_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_rows.size() != 0);
  endtask

  initial begin : stimulus
    in_valid_i = 1'b0;
    block_i    = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tbl[i]) begin
      send_block(directed_tbl[i].blk, directed_tbl[i].known, directed_tbl[i].pix);
    end
    for (int i = 0; i < PhaseItems; i++) send_block(random_block(), 1'b0, '0);
    wait_rows_drained();

    send_idle_pct = 61;
    recv_idle_pct = 20;
    for (int i = 0; i < PhaseItems; i++) send_block(random_block(), 1'b0, '0);
    wait_rows_drained();

    // Full rate; one long output stall lets the pipeline fill and back up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < PhaseItems; i++) begin
      if (i == HoldAtItem) hold_rows = 1'b1;
      send_block(random_block(), 1'b0, '0);
    end
    wait_rows_drained();

    repeat (3 * PipeLatency) @(posedge clk_i);
    if (mismatch_count == 0 && pending_rows.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : drive_ready
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rows) begin
        hold_rows = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_rows
    pixel_row_t       want;
    logic [3:0][31:0] got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rows.size() == 0) begin
        $error("row transaction with nothing expected: row %0d", row_o);
        mismatch_count++;
      end else begin
        want = pending_rows.pop_front();
        got  = {pix3_o, pix2_o, pix1_o, pix0_o};
        if (row_o !== want.row) begin
          $error("row: expected %0d, got %0d", want.row, row_o);
          mismatch_count++;
        end
        for (int c = 0; c < 4; c++) begin
          if (got[c] !== want.pix[c]) begin
            $error("pix%0d: expected %h, got %h", c, want.pix[c], got[c]);
            mismatch_count++;
          end
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
